// File: rtl/svflp_pkg.sv
// Shared types, widths and arithmetic helpers for the four-channel
// state-variable lowpass filter. No dependencies.
package svflp_pkg;

	// Channel count and field widths.
	localparam int CHANNELS  = 4;
	localparam int SAMPLE_W  = 24;
	localparam int FREQ_W    = 24;
	localparam int FQ_W      = 25;
	localparam int ACC_W     = 32;
	localparam int COEF_FRAC = 22;

	// Configuration port.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = FQ_W;
	localparam logic [CFG_IDX_W-1:0] CFG_FREQ    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FREQ_FQ = 2'd1;
	localparam logic [FQ_W-1:0] FQ_RESET = 25'd4194304;

	// Highpass term is kept exact; it is split in two halves for the multiplier.
	localparam int HP_W    = 36;
	localparam int HP_LO_W = 18;
	localparam int HP_HI_W = HP_W - HP_LO_W;

	// Shared lane multiplier: coefficient (zero extended) times a signed operand.
	localparam int MUL_A_W = FQ_W + 1;
	localparam int MUL_B_W = ACC_W + 1;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	// Product register and scaled product widths.
	localparam int PROD_W = 61;
	localparam int SCL_W  = PROD_W - COEF_FRAC + 1;

	// Lane control from the top, and lane status back.
	typedef struct packed {
		logic start;
		logic retire;
	} lane_ctrl_t;

	typedef struct packed {
		logic idle;
		logic done;
	} lane_stat_t;

	// Scale a product by 2^-22, rounding to nearest with ties toward plus infinity.
	function automatic logic signed [SCL_W-1:0] scale_round(input logic signed [PROD_W-1:0] p);
		logic signed [PROD_W:0] t;
		t = {p[PROD_W-1], p} + {{(PROD_W+1-COEF_FRAC){1'b0}}, 1'b1, {(COEF_FRAC-1){1'b0}}};
		return t[PROD_W:COEF_FRAC];
	endfunction

	// Saturate an integrator sum to the accumulator width.
	function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [SCL_W:0] v);
		if (&v[SCL_W:ACC_W-1] || ~|v[SCL_W:ACC_W-1]) begin
			return v[ACC_W-1:0];
		end
		return v[SCL_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
	endfunction

	// Saturate an integrator value to the sample width.
	function automatic logic signed [SAMPLE_W-1:0] sat_out(input logic signed [ACC_W-1:0] v);
		if (&v[ACC_W-1:SAMPLE_W-1] || ~|v[ACC_W-1:SAMPLE_W-1]) begin
			return v[SAMPLE_W-1:0];
		end
		return v[ACC_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
	endfunction

endpackage

// File: rtl/svflp_lane.sv
// One filter lane: band and low integrators of a single channel, updated by
// a short sequence through one shared multiplier. Uses svflp_pkg.
module svflp_lane import svflp_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  lane_ctrl_t                 ctrl,
	input  logic [FREQ_W-1:0]          coef_freq,
	input  logic [FQ_W-1:0]            coef_fq,
	input  logic signed [SAMPLE_W-1:0] sample,
	output lane_stat_t                 stat,
	output logic signed [SAMPLE_W-1:0] lowpass
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_FB,
		ST_HIGHPASS,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_ACCUM,
		ST_BAND,
		ST_MUL_LOW,
		ST_LOW,
		ST_DONE
	} lane_state_t;

	lane_state_t               state_q;
	logic signed [ACC_W-1:0]   band_q;
	logic signed [ACC_W-1:0]   low_q;
	logic signed [SAMPLE_W-1:0] x_q;
	logic signed [HP_W-1:0]    hp_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [PROD_W-1:0]  acc_q;

	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [MUL_P_W-1:0] mul_p;
	logic signed [PROD_W-1:0]  mul_ext;
	logic signed [SCL_W-1:0]   scaled;
	logic signed [SCL_W-1:0]   hp_full;
	logic signed [SCL_W:0]     band_sum;
	logic signed [SCL_W:0]     low_sum;
	logic signed [PROD_W-1:0]  prod_sum;

	// Operand selection for the shared multiplier.
	always_comb begin
		mul_a = {{(MUL_A_W-FREQ_W){1'b0}}, coef_freq};
		mul_b = {band_q[ACC_W-1], band_q};
		case (state_q)
			ST_MUL_FB: begin
				mul_a = {{(MUL_A_W-FQ_W){1'b0}}, coef_fq};
				mul_b = {band_q[ACC_W-1], band_q};
			end
			ST_MUL_LO: begin
				mul_b = {{(MUL_B_W-HP_LO_W){1'b0}}, hp_q[HP_LO_W-1:0]};
			end
			ST_MUL_HI: begin
				mul_b = {{(MUL_B_W-HP_HI_W){hp_q[HP_W-1]}}, hp_q[HP_W-1:HP_LO_W]};
			end
			default: begin
				mul_b = {band_q[ACC_W-1], band_q};
			end
		endcase
	end

	assign mul_p   = mul_a * mul_b;
	assign mul_ext = {{(PROD_W-MUL_P_W){mul_p[MUL_P_W-1]}}, mul_p};
	assign scaled  = scale_round(prod_q);

	// Highpass term and integrator sums, all kept wide enough to be exact.
	assign hp_full = {{(SCL_W-SAMPLE_W){x_q[SAMPLE_W-1]}}, x_q}
		- (scaled + {{(SCL_W-ACC_W){low_q[ACC_W-1]}}, low_q});
	assign band_sum = {{(SCL_W+1-ACC_W){band_q[ACC_W-1]}}, band_q} + {scaled[SCL_W-1], scaled};
	assign low_sum  = {{(SCL_W+1-ACC_W){low_q[ACC_W-1]}}, low_q} + {scaled[SCL_W-1], scaled};
	assign prod_sum = acc_q + (prod_q <<< HP_LO_W);

	// Sequencer and integrator state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			band_q  <= '0;
			low_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (ctrl.start) begin
						state_q <= ST_MUL_FB;
					end
				end
				ST_MUL_FB:   state_q <= ST_HIGHPASS;
				ST_HIGHPASS: state_q <= ST_MUL_LO;
				ST_MUL_LO:   state_q <= ST_MUL_HI;
				ST_MUL_HI:   state_q <= ST_ACCUM;
				ST_ACCUM:    state_q <= ST_BAND;
				ST_BAND: begin
					band_q  <= sat_acc(band_sum);
					state_q <= ST_MUL_LOW;
				end
				ST_MUL_LOW:  state_q <= ST_LOW;
				ST_LOW: begin
					low_q   <= sat_acc(low_sum);
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (ctrl.retire) begin
						state_q <= ST_IDLE;
					end
				end
				default:     state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (ctrl.start) begin
					x_q <= sample;
				end
			end
			ST_MUL_FB:   prod_q <= mul_ext;
			ST_HIGHPASS: hp_q   <= hp_full[HP_W-1:0];
			ST_MUL_LO:   prod_q <= mul_ext;
			ST_MUL_HI: begin
				acc_q  <= prod_q;
				prod_q <= mul_ext;
			end
			ST_ACCUM:    prod_q <= prod_sum;
			ST_MUL_LOW:  prod_q <= mul_ext;
			default: begin
			end
		endcase
	end

	assign stat.idle = (state_q == ST_IDLE);
	assign stat.done = (state_q == ST_DONE);
	assign lowpass   = sat_out(low_q);

endmodule

// File: rtl/svflp_merge.sv
// Merging stage: gathers the lane results into the output register and
// frees the lanes once the result is captured. Uses svflp_pkg.
module svflp_merge import svflp_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  lane_stat_t                 stat [CHANNELS],
	input  logic signed [SAMPLE_W-1:0] lane_lowpass [CHANNELS],
	input  logic                       out_ready,
	output logic                       out_valid,
	output logic signed [SAMPLE_W-1:0] out_lowpass [CHANNELS],
	output logic                       retire
);

	logic [CHANNELS-1:0]        done_v;
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] out_lowpass_q [CHANNELS];

	// All lanes finish together; capture when the output register is free or draining.
	always_comb begin
		for (int c = 0; c < CHANNELS; c++) begin
			done_v[c] = stat[c].done;
		end
	end

	assign retire = (&done_v) && (!out_valid_q || out_ready);

	// Output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (retire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output data register.
	always_ff @(posedge clk) begin
		if (retire) begin
			for (int c = 0; c < CHANNELS; c++) begin
				out_lowpass_q[c] <= lane_lowpass[c];
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign out_lowpass = out_lowpass_q;

endmodule

// File: rtl/svf_lowpass_four_channel_unit.sv
// Top level of the four-channel state-variable lowpass filter: coefficient
// registers, four filter lanes and the merging output stage. Uses svflp_pkg.
//
// Each accepted request carries one sample per channel; four lanes filter
// the channels side by side and one result request returns all four lowpass
// values. An accepted request runs the lane sequence of eight steps through
// each lane's single multiplier (one feedback product, two partial products
// for the band update, one product for the low update, plus add and saturate
// steps), then its result moves into the output register once that is free
// or draining. A new request is taken only once the lanes have handed their
// result to the output register, so requests never overlap in the lanes.
// Coefficients are written through the config port, which is always ready;
// write them only while no request is in flight.
module svf_lowpass_four_channel_unit import svflp_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_DATA_W-1:0]      cfg_data,
	input  logic                       sample_valid,
	output logic                       sample_ready,
	input  logic signed [SAMPLE_W-1:0] sample_ch0,
	input  logic signed [SAMPLE_W-1:0] sample_ch1,
	input  logic signed [SAMPLE_W-1:0] sample_ch2,
	input  logic signed [SAMPLE_W-1:0] sample_ch3,
	output logic                       lowpass_valid,
	input  logic                       lowpass_ready,
	output logic signed [SAMPLE_W-1:0] lowpass_ch0,
	output logic signed [SAMPLE_W-1:0] lowpass_ch1,
	output logic signed [SAMPLE_W-1:0] lowpass_ch2,
	output logic signed [SAMPLE_W-1:0] lowpass_ch3
);

	logic [FREQ_W-1:0]          coef_freq_q;
	logic [FQ_W-1:0]            coef_fq_q;
	logic signed [SAMPLE_W-1:0] sample_a [CHANNELS];
	logic signed [SAMPLE_W-1:0] lane_lowpass [CHANNELS];
	logic signed [SAMPLE_W-1:0] out_lowpass [CHANNELS];
	lane_stat_t                 stat [CHANNELS];
	lane_ctrl_t                 ctrl;
	logic [CHANNELS-1:0]        idle_v;
	logic [CHANNELS-1:0]        done_v;
	logic                       retire;
	logic                       accept;

	// Coefficient registers.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_freq_q <= '0;
			coef_fq_q   <= FQ_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_FREQ:    coef_freq_q <= cfg_data[FREQ_W-1:0];
				CFG_FREQ_FQ: coef_fq_q   <= cfg_data[FQ_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Input request goes to all lanes at once.
	assign sample_a[0] = sample_ch0;
	assign sample_a[1] = sample_ch1;
	assign sample_a[2] = sample_ch2;
	assign sample_a[3] = sample_ch3;

	always_comb begin
		for (int c = 0; c < CHANNELS; c++) begin
			idle_v[c] = stat[c].idle;
			done_v[c] = stat[c].done;
		end
	end

	assign sample_ready = &idle_v;
	assign accept       = sample_valid && sample_ready;
	assign ctrl.start   = accept;
	assign ctrl.retire  = retire;

	// Filter lanes.
	for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
		svflp_lane u_lane (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.coef_freq (coef_freq_q),
			.coef_fq   (coef_fq_q),
			.sample    (sample_a[c]),
			.stat      (stat[c]),
			.lowpass   (lane_lowpass[c])
		);
	end

	// Merge lane results into the output register.
	svflp_merge u_merge (
		.clk          (clk),
		.arst_n       (arst_n),
		.stat         (stat),
		.lane_lowpass (lane_lowpass),
		.out_ready    (lowpass_ready),
		.out_valid    (lowpass_valid),
		.out_lowpass  (out_lowpass),
		.retire       (retire)
	);

	assign lowpass_ch0 = out_lowpass[0];
	assign lowpass_ch1 = out_lowpass[1];
	assign lowpass_ch2 = out_lowpass[2];
	assign lowpass_ch3 = out_lowpass[3];

`ifndef SYNTH
	// Lanes run in lockstep: either all or none have a finished result.
	a_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		(done_v == '0) || (done_v == '1))
		else $error("filter lanes out of step");

	// An accepted request leaves every lane busy in the next cycle.
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (idle_v == '0))
		else $error("lane stayed idle after accepted request");

	// Lanes are freed only into an output register that is free or draining.
	a_retire_room: assert property (@(posedge clk) disable iff (!arst_n)
		retire |-> (!lowpass_valid || lowpass_ready))
		else $error("result overwrote a pending output");
`endif

endmodule

// File: bench/svf_lowpass_four_channel_unit_tb.sv
// Self-checking testbench for the four-channel state-variable lowpass filter.
// Depends on svflp_pkg and svf_lowpass_four_channel_unit; a built-in fixed-point
// filter predictor checks every result request against the sample requests sent.
module svf_lowpass_four_channel_unit_tb;
	import svflp_pkg::*;

	typedef logic [CHANNELS-1:0][SAMPLE_W-1:0] quad_t;

	// Register indexes that the block has no register for.
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

	localparam logic [SAMPLE_W-1:0] S_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
	localparam logic [SAMPLE_W-1:0] S_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
	localparam longint ACC_HI = (longint'(1) <<< (ACC_W-1)) - 1;
	localparam longint ACC_LO = -ACC_HI - 1;
	localparam longint OUT_HI = (longint'(1) <<< (SAMPLE_W-1)) - 1;
	localparam longint OUT_LO = -OUT_HI - 1;
	localparam int SETTLE_CYCLES = 24;
	localparam int QUIET_LIMIT = 2000;

	logic clk;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic sample_valid = 1'b0;
	logic sample_ready;
	logic signed [SAMPLE_W-1:0] sample_ch0 = '0;
	logic signed [SAMPLE_W-1:0] sample_ch1 = '0;
	logic signed [SAMPLE_W-1:0] sample_ch2 = '0;
	logic signed [SAMPLE_W-1:0] sample_ch3 = '0;
	logic lowpass_valid;
	logic lowpass_ready = 1'b0;
	logic signed [SAMPLE_W-1:0] lowpass_ch0;
	logic signed [SAMPLE_W-1:0] lowpass_ch1;
	logic signed [SAMPLE_W-1:0] lowpass_ch2;
	logic signed [SAMPLE_W-1:0] lowpass_ch3;

	// Predictor state: coefficients and the two integrators of each channel.
	longint freq_gain = 0;
	longint damp_gain = longint'(FQ_RESET);
	longint band_acc[CHANNELS] = '{default: 0};
	longint low_acc[CHANNELS] = '{default: 0};

	quad_t sample_backlog[$];
	quad_t lowpass_due[$];
	quad_t predicted, next_frame, seen, wanted;
	bit idle_on = 1'b1;
	int send_gap = 0;
	int stall_left = 0;
	int quiet_cycles = 0;
	int error_count = 0;
	int samples_sent = 0;
	int results_seen = 0;
	int cfg_writes = 0;
	int settings_run = 0;

	svf_lowpass_four_channel_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.sample_ch0(sample_ch0),
		.sample_ch1(sample_ch1),
		.sample_ch2(sample_ch2),
		.sample_ch3(sample_ch3),
		.lowpass_valid(lowpass_valid),
		.lowpass_ready(lowpass_ready),
		.lowpass_ch0(lowpass_ch0),
		.lowpass_ch1(lowpass_ch1),
		.lowpass_ch2(lowpass_ch2),
		.lowpass_ch3(lowpass_ch3)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic longint clip(input longint v, input longint lo, input longint hi);
		if (v < lo) begin
			return lo;
		end
		if (v > hi) begin
			return hi;
		end
		return v;
	endfunction

	// Product scaled by 2^-22, rounded to nearest with ties toward plus infinity.
	function automatic longint round_scale(input longint p);
		return (p + (longint'(1) <<< (COEF_FRAC-1))) >>> COEF_FRAC;
	endfunction

	// One filter step on all channels; advances the integrators.
	function automatic quad_t lowpass_step(input quad_t x);
		quad_t y;
		longint xin, hp, nb, nl;
		for (int c = 0; c < CHANNELS; c++) begin
			xin = longint'($signed(x[c]));
			hp = xin - (round_scale(damp_gain * band_acc[c]) + low_acc[c]);
			nb = clip(band_acc[c] + round_scale(freq_gain * hp), ACC_LO, ACC_HI);
			nl = clip(low_acc[c] + round_scale(freq_gain * nb), ACC_LO, ACC_HI);
			band_acc[c] = nb;
			low_acc[c] = nl;
			y[c] = SAMPLE_W'(clip(nl, OUT_LO, OUT_HI));
		end
		return y;
	endfunction

	function automatic quad_t frame(input logic [SAMPLE_W-1:0] a, input logic [SAMPLE_W-1:0] b,
			input logic [SAMPLE_W-1:0] c, input logic [SAMPLE_W-1:0] d);
		return {d, c, b, a};
	endfunction

	// Random samples: full scale, rails, small values, or a held level for step responses.
	function automatic quad_t random_frame(input quad_t prev);
		quad_t q;
		for (int c = 0; c < CHANNELS; c++) begin
			case ($urandom_range(0, 9))
				0, 1, 2: q[c] = SAMPLE_W'($urandom());
				3: q[c] = $urandom_range(0, 1) ? S_MAX : S_MIN;
				4: q[c] = SAMPLE_W'(int'($urandom_range(0, 511)) - 256);
				default: q[c] = prev[c];
			endcase
		end
		return q;
	endfunction

	// Sample request driver, fed from the backlog; predicts each accepted request.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_valid <= 1'b0;
			send_gap <= 0;
		end else begin
			if (sample_valid && sample_ready) begin
				predicted = lowpass_step({sample_ch3, sample_ch2, sample_ch1, sample_ch0});
				lowpass_due.push_back(predicted);
				samples_sent++;
			end
			if (!sample_valid || sample_ready) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					sample_valid <= 1'b0;
				end else if (sample_backlog.size() > 0) begin
					next_frame = sample_backlog.pop_front();
					sample_valid <= 1'b1;
					sample_ch0 <= next_frame[0];
					sample_ch1 <= next_frame[1];
					sample_ch2 <= next_frame[2];
					sample_ch3 <= next_frame[3];
					if (idle_on && $urandom_range(0, 3) == 0) begin
						send_gap <= $urandom_range(1, 10);
					end
				end else begin
					sample_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor with random back-pressure; compares each channel in order.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lowpass_ready <= 1'b0;
			stall_left <= 0;
		end else begin
			if (lowpass_valid && lowpass_ready) begin
				seen = {lowpass_ch3, lowpass_ch2, lowpass_ch1, lowpass_ch0};
				results_seen++;
				if (lowpass_due.size() == 0) begin
					$display("%0t: unexpected result request, got %h", $time, seen);
					error_count++;
				end else begin
					wanted = lowpass_due.pop_front();
					for (int c = 0; c < CHANNELS; c++) begin
						if (seen[c] !== wanted[c]) begin
							$display("%0t: lowpass_ch%0d expected %0d, got %0d", $time, c,
								$signed(wanted[c]), $signed(seen[c]));
							error_count++;
						end
					end
				end
			end
			if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				lowpass_ready <= 1'b0;
			end else begin
				lowpass_ready <= 1'b1;
				if (idle_on && $urandom_range(0, 5) == 0) begin
					stall_left <= $urandom_range(1, 10);
				end
			end
		end
	end

	// Watchdog: too many cycles without any accepted request ends the run.
	always @(posedge clk) begin
		if (!arst_n || (sample_valid && sample_ready) || (lowpass_valid && lowpass_ready)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no request accepted for %0d cycles", $time, QUIET_LIMIT);
			$display("simulation failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Write one coefficient register and mirror it in the predictor.
	task automatic set_coef(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cfg_writes++;
		case (idx)
			CFG_FREQ: freq_gain = longint'(val[FREQ_W-1:0]);
			CFG_FREQ_FQ: damp_gain = longint'(val);
			default: ;
		endcase
	endtask

	// Wait until every sample request has been sent and every result has arrived.
	task automatic drain();
		while (sample_backlog.size() > 0 || sample_valid || lowpass_due.size() > 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic retune(input logic [CFG_DATA_W-1:0] f, input logic [CFG_DATA_W-1:0] fq);
		drain();
		set_coef(CFG_FREQ, f);
		set_coef(CFG_FREQ_FQ, fq);
		settings_run++;
	endtask

	task automatic run_random(input int count);
		quad_t prev;
		prev = '0;
		repeat (count) begin
			prev = random_frame(prev);
			sample_backlog.push_back(prev);
		end
	endtask

	// Main sequence: reset, directed frames, then random phases over several tunings.
	initial begin
		logic [FREQ_W-1:0] f_rand;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset coefficients keep the filter at rest.
		settings_run++;
		sample_backlog.push_back(frame(S_MAX, S_MAX, S_MAX, S_MAX));
		sample_backlog.push_back(frame(S_MIN, S_MIN, S_MIN, S_MIN));
		sample_backlog.push_back('0);

		// Moderate tuning; writes to unused indexes must change nothing.
		retune(25'd2097152, 25'd6291456);
		set_coef(CFG_SPARE_2, '1);
		set_coef(CFG_SPARE_3, '1);
		sample_backlog.push_back(frame(S_MAX, S_MIN, '0, '1));
		sample_backlog.push_back(frame(S_MIN, S_MAX, 24'd1, '0));
		sample_backlog.push_back(frame(24'h555555, 24'hAAAAAA, 24'h0F0F0F, 24'hF0F0F0));
		sample_backlog.push_back(frame(24'hAAAAAA, 24'h555555, 24'hF0F0F0, 24'h0F0F0F));
		sample_backlog.push_back(frame(S_MAX, S_MAX, S_MIN, S_MIN));
		sample_backlog.push_back(frame(S_MAX, S_MAX, S_MIN, S_MIN));
		sample_backlog.push_back(frame(S_MIN, '1, S_MAX, 24'd1));
		sample_backlog.push_back('0);
		sample_backlog.push_back('1);
		sample_backlog.push_back(frame(S_MAX, S_MIN, S_MAX, S_MIN));

		// Full-scale gain with no damping grows until integrators and outputs clamp.
		retune(25'h0FFFFFF, '0);
		repeat (5) sample_backlog.push_back(frame(S_MAX, S_MIN, S_MAX, S_MIN));
		repeat (5) sample_backlog.push_back(frame(S_MIN, S_MAX, '0, S_MAX));

		retune(25'd1048576, 25'd6920602);
		run_random(200);
		retune(CFG_DATA_W'($urandom_range(0, 8388608)), CFG_DATA_W'($urandom_range(0, 16777216)));
		run_random(200);
		retune(25'd8388608, 25'd16777216);
		run_random(200);
		retune('0, '1);
		run_random(200);
		idle_on = 1'b0;
		retune(25'd41943, 25'd2139095);
		run_random(200);
		idle_on = 1'b1;
		// Bit 24 of the frequency write lies above the register and is dropped.
		retune('1, CFG_DATA_W'($urandom()));
		run_random(200);
		// Final stretch runs at full rate on both sides.
		idle_on = 1'b0;
		f_rand = FREQ_W'($urandom_range(0, 4194304));
		retune({1'b0, f_rand}, CFG_DATA_W'(f_rand) + CFG_DATA_W'($urandom_range(0, 8388608)));
		run_random(200);
		drain();

		if (lowpass_due.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, lowpass_due.size());
			error_count++;
		end
		$display("Covered %0d sample requests and %0d results over %0d coefficient settings,",
			samples_sent, results_seen, settings_run);
		$display("with %0d register writes and %0d mismatches.", cfg_writes, error_count);
		if (error_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

// File: filelist.f
rtl/svflp_pkg.sv
rtl/svflp_lane.sv
rtl/svflp_merge.sv
rtl/svf_lowpass_four_channel_unit.sv
bench/svf_lowpass_four_channel_unit_tb.sv
